// File: hw/rtl/rmgd_pkg.sv
`timescale 1ns / 1ps
package rmgd_pkg;

   localparam int PAL_ENTRIES = 64;
   localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
   localparam int ADDR_W      = 24;

   localparam int CODE_W      = 8;
   localparam int VALUE_W     = 6;
   localparam int INDEX_W     = 6;
   localparam int COLOUR_W    = 8;
   localparam int PIX_ADDR_W  = 24;
   localparam int ORIGIN_W    = 24;
   localparam int PITCH_W     = 16;

   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 24;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [CODE_W-1:0] CODE_STOP = 8'hFF;
   localparam logic [1:0]        OP_FILL   = 2'b00;
   localparam logic [1:0]        OP_SELECT = 2'b01;
   localparam logic [1:0]        OP_SKIP   = 2'b10;
   localparam logic [1:0]        OP_LINES  = 2'b11;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH  = 1'b1;

   localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd640;

   typedef enum logic [2:0] {
      K_PAL,
      K_STOP,
      K_FILL,
      K_SELECT,
      K_SKIP,
      K_LINES
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [VALUE_W-1:0]    n;
      logic [INDEX_W-1:0]    pal_idx;
      logic [COLOUR_W-1:0]   pal_colour;
   } item_type;

   typedef struct packed {
      logic [ORIGIN_W-1:0] origin;
      logic [PITCH_W-1:0]  pitch;
   } cfg_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_FILL_RD,
      B_FILL,
      B_LINES
   } back_state_type;

endpackage

// File: hw/rtl/rmgd_ram.sv
`timescale 1ns / 1ps
module rmgd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rmgd_queue.sv
`timescale 1ns / 1ps
module rmgd_queue
   import rmgd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full     = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/rmgd_front.sv
`timescale 1ns / 1ps
module rmgd_front
   import rmgd_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output item_type              q_item
);

   logic [CODE_W-1:0] code;

   assign code       = req_tdata[CODE_W-1:0];
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_item.n          = code[VALUE_W-1:0];
      q_item.pal_idx    = req_tdata[CODE_W +: INDEX_W];
      q_item.pal_colour = req_tdata[CODE_W + INDEX_W +: COLOUR_W];
      if (req_tuser) begin
         q_item.kind = K_PAL;
      end else if (code == CODE_STOP) begin
         q_item.kind = K_STOP;
      end else begin
         case (code[CODE_W-1 -: 2])
            OP_FILL:   q_item.kind = K_FILL;
            OP_SELECT: q_item.kind = K_SELECT;
            OP_SKIP:   q_item.kind = K_SKIP;
            OP_LINES:  q_item.kind = K_LINES;
            default:   q_item.kind = K_FILL;
         endcase
      end
   end

endmodule

// File: hw/rtl/rmgd_back.sv
`timescale 1ns / 1ps
module rmgd_back
   import rmgd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_empty,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   back_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]     wa_ff, wa_in;
   logic [ADDR_W-1:0]     nl_ff, nl_in;
   logic [VALUE_W-1:0]    ci_ff, ci_in;
   logic                  fresh_ff, fresh_in;
   logic [VALUE_W-1:0]    count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [COLOUR_W-1:0]   rsp_colour_ff, rsp_colour_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  out_free;
   logic [ADDR_W-1:0]     origin_a;
   logic [ADDR_W-1:0]     origin_nl;
   logic [ADDR_W-1:0]     pitch_a;
   logic [ADDR_W-1:0]     wa_base;
   logic [ADDR_W-1:0]     nl_base;
   logic [VALUE_W-1:0]    ci_base;

   logic                  pal_wr_en;
   logic [COLOUR_W-1:0]   pal_rd_data;
   logic [COLOUR_W-1:0]   pix_colour;

   rmgd_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (PAL_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (PAL_AW'(q_item.pal_idx)),
      .wr_data (q_item.pal_colour),
      .rd_addr (PAL_AW'(ci_ff)),
      .rd_data (pal_rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign origin_a   = ADDR_W'(cfg.origin);
   assign pitch_a    = ADDR_W'(cfg.pitch);
   assign origin_nl  = origin_a + pitch_a;
   assign wa_base    = fresh_ff ? origin_a  : wa_ff;
   assign nl_base    = fresh_ff ? origin_nl : nl_ff;
   assign ci_base    = fresh_ff ? '0        : ci_ff;
   assign pix_colour = (32'(ci_ff) < PAL_ENTRIES) ? pal_rd_data : '0;

   always_comb begin
      state_in      = state_ff;
      wa_in         = wa_ff;
      nl_in         = nl_ff;
      ci_in         = ci_ff;
      fresh_in      = fresh_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      q_pop         = 1'b0;
      pal_wr_en     = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               case (q_item.kind)
                  K_PAL: begin
                     q_pop     = 1'b1;
                     pal_wr_en = (32'(q_item.pal_idx) < PAL_ENTRIES);
                  end
                  K_STOP: begin
                     if (out_free) begin
                        q_pop         = 1'b1;
                        fresh_in      = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_addr_in   = '0;
                        rsp_colour_in = '0;
                        rsp_last_in   = 1'b1;
                        rsp_done_in   = 1'b1;
                     end
                  end
                  default: begin
                     q_pop    = 1'b1;
                     fresh_in = 1'b0;
                     wa_in    = wa_base;
                     nl_in    = nl_base;
                     ci_in    = ci_base;
                     case (q_item.kind)
                        K_FILL: begin
                           if (q_item.n != '0) begin
                              count_in = q_item.n;
                              state_in = B_FILL_RD;
                           end
                        end
                        K_SELECT: begin
                           ci_in = q_item.n;
                           wa_in = origin_a;
                           nl_in = origin_nl;
                        end
                        K_SKIP: begin
                           wa_in = wa_base + ADDR_W'(q_item.n);
                        end
                        K_LINES: begin
                           if (q_item.n != '0) begin
                              count_in = q_item.n;
                              state_in = B_LINES;
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               endcase
            end
         end
         B_FILL_RD: begin
            state_in = B_FILL;
         end
         B_FILL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = PIX_ADDR_W'(wa_ff);
               rsp_colour_in = pix_colour;
               rsp_last_in   = (count_ff == VALUE_W'(1));
               rsp_done_in   = 1'b0;
               wa_in         = wa_ff + 1'b1;
               count_in      = count_ff - 1'b1;
               if (count_ff == VALUE_W'(1)) begin
                  state_in = B_IDLE;
               end
            end
         end
         B_LINES: begin
            wa_in    = nl_ff;
            nl_in    = nl_ff + pitch_a;
            count_in = count_ff - 1'b1;
            if (count_ff == VALUE_W'(1)) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wa_ff        <= '0;
         nl_ff        <= '0;
         ci_ff        <= '0;
         fresh_ff     <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wa_ff        <= wa_in;
         nl_ff        <= nl_in;
         ci_ff        <= ci_in;
         fresh_ff     <= fresh_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_colour_ff, rsp_addr_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

endmodule

// File: hw/rtl/rle_multicolour_glyph_draw.sv
`timescale 1ns / 1ps
// Run-length image decoder: turns code bytes into framebuffer pixel writes.
// req channel: one beat per code byte (tuser 0) or palette write (tuser 1).
// rsp channel: one beat per pixel written; tlast marks the final beat of a
// code, tuser marks the done beat of a stop code (address and colour zero).
// csr port: index 0 origin address, index 1 line pitch; write while idle.
// Accepted beats enter a four-entry queue; the executing side pulls one
// item per cycle when it is free.
// A fill code passes the queue, a palette read state and the output register
// before its first pixel shows, then gives one pixel per cycle while rsp_tready
// is high. A line-advance code runs the line-step loop once per line; select,
// skip, stop and palette writes finish in the idle state. No new item leaves
// the queue until a fill or line-advance loop ends.
// Reset empties the queue, drops any pending rsp beat, sets pitch to 640,
// origin to 0 and re-arms at the origin; palette contents stay undefined.
// When rsp_tready is low the pending beat holds and the fill loop waits;
// req beats are still taken until the queue fills.
module rle_multicolour_glyph_draw
   import rmgd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // code_byte, palette_index, palette_colour, pad
   input  logic                  req_tuser,  // func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // pixel_address, pixel_colour
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,  // image_done
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   item_type q_pop_item;
   logic     q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin <= '0;
         cfg_ff.pitch  <= PITCH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN: cfg_ff.origin <= ORIGIN_W'(csr_wdata);
            CSR_PITCH:  cfg_ff.pitch  <= PITCH_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   rmgd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_push_item)
   );

   rmgd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   rmgd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_item     (q_pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/rmgd_checker.sv
`timescale 1ns / 1ps
module rmgd_checker
   import rmgd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   a_done_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("done beat not last or not zero");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && !rsp_tuser)
      else $error("fill run broken before its last beat");

   a_run_address: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tdata[PIX_ADDR_W-1:0] == PIX_ADDR_W'($past(rsp_tdata[PIX_ADDR_W-1:0]) + 1'b1))
      else $error("fill run address not consecutive");

endmodule

bind rle_multicolour_glyph_draw rmgd_checker u_rmgd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// File: verif/rle_multicolour_glyph_draw_tb.sv
`timescale 1ns / 1ps
module rle_multicolour_glyph_draw_tb;
   import rmgd_pkg::*;

   localparam int DRAIN_CYCLES = 300;
   localparam int PHASE_BEATS  = 20;

   typedef struct packed {
      logic                func;
      logic [CODE_W-1:0]   code;
      logic [INDEX_W-1:0]  pal_idx;
      logic [COLOUR_W-1:0] pal_colour;
   } req_beat_t;

   typedef struct packed {
      logic [PIX_ADDR_W-1:0] addr;
      logic [COLOUR_W-1:0]   colour;
      logic                  last;
      logic                  done;
   } pixel_write_t;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_ONE
   } row_check_t;

   typedef struct packed {
      req_beat_t    beat;
      row_check_t   chk;
      pixel_write_t exp;
   } directed_row_t;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_ORIGIN;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   rle_multicolour_glyph_draw dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("simulation failed");
      $finish;
   end

   // decoder image of the block
   logic [ORIGIN_W-1:0]   origin_q   = '0;
   logic [PITCH_W-1:0]    pitch_q    = PITCH_RESET;
   logic [PIX_ADDR_W-1:0] cur_addr   = '0;
   logic [PIX_ADDR_W-1:0] line_addr  = '0;
   logic [VALUE_W-1:0]    colour_sel = '0;
   bit                    fresh      = 1'b1;
   logic [COLOUR_W-1:0]   palette   [PAL_ENTRIES];
   bit                    pal_valid [PAL_ENTRIES];

   pixel_write_t staged[$];
   pixel_write_t pixel_writes_due[$];
   int           fault_count = 0;

   function automatic void return_home();
      cur_addr  = origin_q;
      line_addr = origin_q + PIX_ADDR_W'(pitch_q);
   endfunction

   function automatic void decode_beat(req_beat_t b);
      int unsigned  run;
      pixel_write_t w;
      run = 32'(b.code[VALUE_W-1:0]);
      if (b.func) begin
         palette[b.pal_idx]   = b.pal_colour;
         pal_valid[b.pal_idx] = 1'b1;
         return;
      end
      if (b.code == CODE_STOP) begin
         w = '{'0, '0, 1'b1, 1'b1};
         staged.push_back(w);
         fresh = 1'b1;
         return;
      end
      if (fresh) begin
         return_home();
         colour_sel = '0;
         fresh      = 1'b0;
      end
      case (b.code[CODE_W-1:VALUE_W])
         OP_FILL: begin
            for (int unsigned i = 0; i < run; i++) begin
               w.addr   = cur_addr;
               w.colour = palette[colour_sel];
               w.last   = (i + 1 == run);
               w.done   = 1'b0;
               staged.push_back(w);
               cur_addr = cur_addr + 1'b1;
            end
         end
         OP_SELECT: begin
            colour_sel = b.code[VALUE_W-1:0];
            return_home();
         end
         OP_SKIP: begin
            cur_addr = cur_addr + PIX_ADDR_W'(run);
         end
         default: begin
            repeat (run) begin
               cur_addr  = line_addr;
               line_addr = cur_addr + PIX_ADDR_W'(pitch_q);
            end
         end
      endcase
   endfunction

   function automatic int unsigned beat_gap();
      int unsigned p;
      p = $urandom_range(99);
      if (p < 45)
         return 0;
      if (p < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_beat_t random_beat();
      req_beat_t   b;
      int unsigned p;
      int unsigned run;
      b.func       = 1'b0;
      b.code       = CODE_W'($urandom_range(255));
      b.pal_idx    = INDEX_W'($urandom_range(PAL_ENTRIES - 1));
      b.pal_colour = COLOUR_W'($urandom_range(255));
      p = $urandom_range(99);
      if ($urandom_range(99) < 70)
         run = $urandom_range(0, 6);
      else if ($urandom_range(99) < 70)
         run = $urandom_range(7, 20);
      else
         run = $urandom_range(21, 63);
      if (p < 15)
         b.func = 1'b1;
      else if (p < 50)
         b.code = {OP_FILL, VALUE_W'(run)};
      else if (p < 60)
         b.code = {OP_SELECT, VALUE_W'($urandom_range(63))};
      else if (p < 70)
         b.code = {OP_SKIP, VALUE_W'($urandom_range(63))};
      else if (p < 80)
         b.code = {OP_LINES, VALUE_W'((run > 62) ? 62 : run)};
      else if (p < 88)
         b.code = CODE_STOP;
      return b;
   endfunction

   task automatic send_beat(req_beat_t b);
      int unsigned gap;
      gap = beat_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.func;
      req_tdata  <= {2'b00, b.pal_colour, b.pal_idx, b.code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      while (staged.size() != 0)
         pixel_writes_due.push_back(staged.pop_front());
   endtask

   task automatic send_random_beat();
      req_beat_t b;
      req_beat_t load;
      logic [VALUE_W-1:0] sel;
      b   = random_beat();
      sel = fresh ? '0 : colour_sel;
      if (!b.func && b.code != CODE_STOP && b.code[CODE_W-1:VALUE_W] == OP_FILL
          && b.code[VALUE_W-1:0] != 0 && !pal_valid[sel]) begin
         load.func       = 1'b1;
         load.code       = CODE_W'($urandom_range(255));
         load.pal_idx    = sel;
         load.pal_colour = COLOUR_W'($urandom_range(255));
         decode_beat(load);
         send_beat(load);
      end
      decode_beat(b);
      send_beat(b);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pixel_writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_frame(logic [ORIGIN_W-1:0] origin, logic [PITCH_W-1:0] pitch);
      csr_we    <= 1'b1;
      csr_index <= CSR_ORIGIN;
      csr_wdata <= origin;
      @(posedge clock);
      csr_index <= CSR_PITCH;
      csr_wdata <= CSR_DATA_W'(pitch);
      @(posedge clock);
      csr_we   <= 1'b0;
      origin_q  = origin;
      pitch_q   = pitch;
   endtask

   directed_row_t opening_rows [24] = '{
      '{'{1'b0, CODE_STOP, 6'd0, 8'h00}, CHK_ONE, '{24'd0, 8'h00, 1'b1, 1'b1}},
      '{'{1'b1, 8'h00, 6'd0, 8'hA5}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b1, 8'hFF, 6'd63, 8'hFF}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd1}, 6'd0, 8'h00}, CHK_ONE, '{24'd0, 8'hA5, 1'b1, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd0}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd63}, 6'd0, 8'h00}, CHK_MODEL, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_SELECT, 6'd63}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd3}, 6'd0, 8'h00}, CHK_MODEL, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b1, 8'h00, 6'd63, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd2}, 6'd0, 8'h00}, CHK_MODEL, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_SKIP, 6'd63}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_SKIP, 6'd0}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd1}, 6'd0, 8'h00}, CHK_MODEL, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_LINES, 6'd62}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_LINES, 6'd0}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_LINES, 6'd1}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd4}, 6'd0, 8'h00}, CHK_MODEL, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_SELECT, 6'd0}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd1}, 6'd0, 8'h00}, CHK_MODEL, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, CODE_STOP, 6'd0, 8'h00}, CHK_ONE, '{24'd0, 8'h00, 1'b1, 1'b1}},
      '{'{1'b1, 8'h00, 6'd21, 8'h5A}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_SELECT, 6'd21}, 6'd0, 8'h00}, CHK_NONE, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, {OP_FILL, 6'd2}, 6'd0, 8'h00}, CHK_MODEL, '{24'd0, 8'h00, 1'b0, 1'b0}},
      '{'{1'b0, CODE_STOP, 6'd0, 8'h00}, CHK_ONE, '{24'd0, 8'h00, 1'b1, 1'b1}}
   };

   initial begin
      logic [ORIGIN_W-1:0] origin;
      logic [PITCH_W-1:0]  pitch;
      req_beat_t           stop_beat;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_rows[r]) begin
         decode_beat(opening_rows[r].beat);
         if (opening_rows[r].chk != CHK_MODEL) begin
            staged.delete();
            if (opening_rows[r].chk == CHK_ONE)
               staged.push_back(opening_rows[r].exp);
         end
         send_beat(opening_rows[r].beat);
      end
      for (int p = 0; p < 4; p++) begin
         settle();
         case (p)
            0: begin
               origin = '1;
               pitch  = '1;
            end
            1: begin
               origin = '0;
               pitch  = '0;
            end
            2: begin
               origin = ORIGIN_W'($urandom_range(24'hFFFFFF));
               pitch  = PITCH_W'($urandom_range(16'hFFFF));
            end
            default: begin
               origin = ORIGIN_W'($urandom_range(24'hFFFFFF, 24'hFFF000));
               pitch  = PITCH_RESET;
            end
         endcase
         program_frame(origin, pitch);
         repeat (PHASE_BEATS) send_random_beat();
         stop_beat = '{1'b0, CODE_STOP, '0, '0};
         decode_beat(stop_beat);
         send_beat(stop_beat);
      end
      settle();
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   int ready_left = 0;

   always @(posedge clock) begin
      int unsigned p;
      if (ready_left > 0) begin
         ready_left <= ready_left - 1;
      end else begin
         p = $urandom_range(99);
         if (p < 55) begin
            rsp_tready <= 1'b1;
            ready_left <= $urandom_range(1, 24);
         end else if (p < 90) begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(8, 30);
         end
      end
   end

   always @(posedge clock) begin
      pixel_write_t got;
      pixel_write_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.addr   = rsp_tdata[PIX_ADDR_W-1:0];
         got.colour = rsp_tdata[PIX_ADDR_W +: COLOUR_W];
         got.last   = rsp_tlast;
         got.done   = rsp_tuser;
         if (pixel_writes_due.size() == 0) begin
            $error("unexpected rsp beat: address %h colour %h last %b done %b",
                   got.addr, got.colour, got.last, got.done);
            fault_count++;
         end else begin
            want = pixel_writes_due.pop_front();
            if (got.addr !== want.addr) begin
               $error("pixel_address: expected %h, got %h", want.addr, got.addr);
               fault_count++;
            end
            if (got.colour !== want.colour) begin
               $error("pixel_colour: expected %h, got %h", want.colour, got.colour);
               fault_count++;
            end
            if (got.last !== want.last) begin
               $error("last_of_run: expected %b, got %b", want.last, got.last);
               fault_count++;
            end
            if (got.done !== want.done) begin
               $error("image_done: expected %b, got %b", want.done, got.done);
               fault_count++;
            end
         end
      end
   end

endmodule
